FILE: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising edge outside of reset.
`define ASSERT_CLK(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");

// Check that a condition never holds outside of reset.
`define ASSERT_NEVER(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("forbidden condition seen");

`endif

FILE: rtl/core/sipq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sipq_pkg
// Types and codes of the sorted insertion priority queue.
// ----------------------------------------------------------------------------
package sipq_pkg;

  typedef struct packed {
    logic [15:0] prio;
    logic [7:0]  target;
    logic [7:0]  user;
  } entry_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_t;

  typedef enum logic {
    CMD_ENQ = 1'b0,
    CMD_DEQ = 1'b1
  } cmd_t;

  localparam int CAP_W = 5;

endpackage

FILE: rtl/core/sipq_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sipq_ram
// Entry store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module sipq_ram
  import sipq_pkg::*;
#(
  parameter int DEPTH = 16,
  parameter int IDX_W = 4
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  entry_t           wr_data,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_addr,
  output entry_t           rd_data
);

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/core/sorted_insert_priority_queue_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_insert_priority_queue_top
// Priority queue kept sorted in a ring of entries by descending priority.
// ----------------------------------------------------------------------------
// One request is worked on at a time. A dequeue reads the head entry at
// transfer, takes it into the result in S_DQD and loads it out in S_DONE. An
// enqueue walks from the tail toward the head, one stored entry at a time (a
// store read, then a priority compare and a shift write), and stops when it
// reaches the head or an entry of equal or higher priority; the single read
// port of the entry store makes the read and the compare separate steps.
// Rejected requests (enqueue when full, dequeue when empty) go straight to the
// result. A finished result sits in the output register until taken, and the
// next request is taken once that result has been loaded there. Writing
// capacity empties the queue.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sorted_insert_priority_queue_top
  import sipq_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [4:0]  cfg_data,     // capacity
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,      // in_user, in_target, in_priority
  input  logic        s_tuser,      // cmd
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,      // out_user, out_target, out_priority, status, occupancy
  output logic        m_tuser       // out_valid
);

  localparam int IDX_W   = $clog2(DEPTH);
  localparam int CAP_MAX = (DEPTH < 31) ? DEPTH : 31;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_CMP,
    S_PUT,
    S_DQD,
    S_DONE
  } state_t;

  state_t           state;
  logic [CAP_W-1:0] cap;
  logic [IDX_W-1:0] cap_m1;
  logic [IDX_W-1:0] head;
  logic [IDX_W-1:0] tail;
  logic [CAP_W-1:0] count;
  logic [IDX_W-1:0] pos;
  entry_t           ins;
  entry_t           res_entry;
  logic             res_valid;
  status_t          res_status;

  logic             accept;
  logic [IDX_W-1:0] pos_prev;
  logic [IDX_W-1:0] tail_adv;
  logic [IDX_W-1:0] head_adv;
  logic [IDX_W-1:0] slot;
  logic             shift;
  logic [31:0]      cap_v;
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  entry_t           ram_wdata;
  logic             ram_re;
  logic [IDX_W-1:0] ram_raddr;
  entry_t           ram_rdata;

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;

  assign pos_prev = (pos == '0) ? cap_m1 : pos - 1'b1;
  assign tail_adv = (tail == cap_m1) ? '0 : tail + 1'b1;
  assign head_adv = (head == cap_m1) ? '0 : head + 1'b1;
  assign slot     = (count == '0) ? '0 : tail_adv;
  assign shift    = ins.prio > ram_rdata.prio;

  always_comb begin
    cap_v = (cfg_data == '0) ? 32'd1 : {27'd0, cfg_data};
    if (cap_v > 32'(CAP_MAX)) begin
      cap_v = 32'(CAP_MAX);
    end
  end

  always_comb begin
    ram_we    = ((state == S_CMP) && shift) || (state == S_PUT);
    ram_waddr = pos;
    ram_wdata = (state == S_PUT) ? ins : ram_rdata;
    ram_re    = (state == S_RD) || (accept && (s_tuser == CMD_DEQ));
    ram_raddr = (state == S_RD) ? pos_prev : head;
  end

  sipq_ram #(
    .DEPTH (DEPTH),
    .IDX_W (IDX_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      cap      <= CAP_W'(CAP_MAX);
      cap_m1   <= IDX_W'(CAP_MAX - 1);
      head     <= '0;
      tail     <= '0;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tready && (state != S_DONE)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            res_valid <= 1'b0;
            if (s_tuser == CMD_ENQ) begin
              if (count >= cap) begin
                res_status <= STAT_FULL;
                state      <= S_DONE;
              end else begin
                res_status <= STAT_OK;
                tail  <= slot;
                count <= count + 1'b1;
                pos   <= slot;
                ins   <= s_tdata;
                if (count == '0) begin
                  head  <= '0;
                  state <= S_PUT;
                end else if (slot == head) begin
                  state <= S_PUT;
                end else begin
                  state <= S_RD;
                end
              end
            end else begin
              if (count == '0) begin
                res_status <= STAT_EMPTY;
                state      <= S_DONE;
              end else begin
                res_status <= STAT_OK;
                state      <= S_DQD;
              end
            end
          end
        end
        S_RD: begin
          state <= S_CMP;
        end
        S_CMP: begin
          if (shift) begin
            pos   <= pos_prev;
            state <= (pos_prev == head) ? S_PUT : S_RD;
          end else begin
            state <= S_PUT;
          end
        end
        S_PUT: begin
          state <= S_DONE;
        end
        S_DQD: begin
          res_entry <= ram_rdata;
          res_valid <= 1'b1;
          count     <= count - 1'b1;
          if (count == CAP_W'(1)) begin
            head <= '0;
            tail <= '0;
          end else begin
            head <= head_adv;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tuser  <= res_valid;
            m_tdata  <= {1'b0, count, res_status, res_valid ? res_entry : entry_t'('0)};
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if (cfg_we) begin
        cap    <= cap_v[CAP_W-1:0];
        cap_m1 <= IDX_W'(cap_v - 32'd1);
        head   <= '0;
        tail   <= '0;
        count  <= '0;
      end
    end
  end

  `ASSERT_NEVER(a_count_le_cap, clk, rst, count > cap)
  `ASSERT_CLK(a_empty_at_zero, clk, rst, (count == '0) |-> ((head == '0) && (tail == '0)))
  `ASSERT_CLK(a_one_at_a_time, clk, rst, accept |=> !s_tready)
  `ASSERT_CLK(a_entry_ok, clk, rst, (m_tvalid && m_tuser) |-> (m_tdata[33:32] == STAT_OK))

endmodule

FILE: tb/sorted_insert_priority_queue_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_insert_priority_queue_top_tb
// Self-checking bench for the sorted insertion priority queue.
// ----------------------------------------------------------------------------
// A short table of requests covers the empty and full rejects, the extreme
// field values, ordering among equal priorities and capacity clamping. After
// the table, random enqueue/dequeue mixes run under a series of capacity
// settings, predicted by a priority list kept in the bench; random gaps on
// both stream sides shift timing against the queue's walks.
// ----------------------------------------------------------------------------
module sorted_insert_priority_queue_top_tb;
  import sipq_pkg::*;

  localparam int DEPTH      = 16;
  localparam int PHASE_LEN  = 175;

  typedef struct packed {
    logic        ov;
    logic [7:0]  u;
    logic [7:0]  t;
    logic [15:0] p;
    status_t     st;
    logic [4:0]  occ;
  } res_t;

  typedef enum logic {ROW_REQ, ROW_CAP} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    cmd_t        cmd;
    logic [7:0]  u;
    logic [7:0]  t;
    logic [15:0] p;
    logic [4:0]  cap;
    bit          typed;
    res_t        want;
  } row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [4:0]  cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic        m_tuser;

  entry_t      held_q[$];
  res_t        pending_results[$];
  int unsigned cap_now = DEPTH;
  bit          quiet = 1'b0;
  int          bad_cnt = 0;
  int          n_requests = 0;
  int          n_served = 0;
  int          n_full_rej = 0;
  int          n_empty_rej = 0;
  int          n_caps = 0;

  sorted_insert_priority_queue_top #(.DEPTH(DEPTH)) u_top (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic res_t serve_request(cmd_t c, logic [7:0] u, logic [7:0] t,
                                         logic [15:0] p);
    res_t   r;
    entry_t e;
    int     pos;
    r = '{ov: 1'b0, u: '0, t: '0, p: '0, st: STAT_OK, occ: '0};
    if (c == CMD_ENQ) begin
      if (held_q.size() >= cap_now) begin
        r.st = STAT_FULL;
      end else begin
        e.user = u;
        e.target = t;
        e.prio = p;
        pos = 0;
        while (pos < held_q.size() && held_q[pos].prio >= p) pos++;
        held_q.insert(pos, e);
      end
    end else begin
      if (held_q.size() == 0) begin
        r.st = STAT_EMPTY;
      end else begin
        e = held_q.pop_front();
        r.ov = 1'b1;
        r.u = e.user;
        r.t = e.target;
        r.p = e.prio;
      end
    end
    r.occ = 5'(held_q.size());
    return r;
  endfunction

  task automatic send_request(cmd_t c, logic [7:0] u, logic [7:0] t, logic [15:0] p,
                              bit typed, res_t want);
    res_t r;
    s_tvalid <= 1'b1;
    s_tuser  <= c;
    s_tdata  <= {p, t, u};
    do @(posedge clk); while (!s_tready);
    r = serve_request(c, u, t, p);
    n_requests++;
    if (r.ov) n_served++;
    if (r.st == STAT_FULL) n_full_rej++;
    if (r.st == STAT_EMPTY) n_empty_rej++;
    pending_results.push_back(typed ? want : r);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  task automatic set_capacity(logic [4:0] v);
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we   <= 1'b0;
    cap_now = (v == 0) ? 1 : ((v > DEPTH) ? DEPTH : v);
    held_q.delete();
    n_caps++;
  endtask

  task automatic run_mix(int n);
    int          enq_pct;
    cmd_t        c;
    logic [15:0] p;
    res_t        none;
    none = '0;
    enq_pct = 50;
    for (int i = 0; i < n; i++) begin
      if (i % 20 == 0) enq_pct = 25 + 25 * $urandom_range(0, 2);
      c = ($urandom_range(0, 99) < enq_pct) ? CMD_ENQ : CMD_DEQ;
      case ($urandom_range(0, 7))
        0:       p = 16'h0000;
        1:       p = 16'hffff;
        2, 3:    p = 16'($urandom);
        default: p = 16'($urandom_range(0, 7));
      endcase
      send_request(c, 8'($urandom), 8'($urandom), p, 1'b0, none);
    end
  endtask

  // check results in order of acceptance
  always @(posedge clk) begin : result_check
    res_t got;
    res_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.ov  = m_tuser;
      got.u   = m_tdata[7:0];
      got.t   = m_tdata[15:8];
      got.p   = m_tdata[31:16];
      got.st  = status_t'(m_tdata[33:32]);
      got.occ = m_tdata[38:34];
      if (pending_results.size() == 0) begin
        bad_cnt++;
        if (bad_cnt <= 10)
          $display("unexpected result: v=%0d u=%h t=%h p=%h st=%0d occ=%0d",
                   got.ov, got.u, got.t, got.p, got.st, got.occ);
      end else begin
        want = pending_results.pop_front();
        if (got.ov !== want.ov || got.u !== want.u || got.t !== want.t ||
            got.p !== want.p || got.st !== want.st || got.occ !== want.occ ||
            m_tdata[39] !== 1'b0) begin
          bad_cnt++;
          if (bad_cnt <= 10) begin
            $display("mismatch exp: v=%0d u=%h t=%h p=%h st=%0d occ=%0d",
                     want.ov, want.u, want.t, want.p, want.st, want.occ);
            $display("         got: v=%0d u=%h t=%h p=%h st=%0d occ=%0d pad=%b",
                     got.ov, got.u, got.t, got.p, got.st, got.occ, m_tdata[39]);
          end
        end
      end
    end
  end

  // random output stalls in bursts
  int stall_left = 0;
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_tready   <= 1'b0;
    end else if (!quiet && $urandom_range(0, 3) == 0) begin
      stall_left <= $urandom_range(0, 4);
      m_tready   <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  initial begin
    row_t        dir_tbl [0:16];
    logic [4:0]  caps [0:9];
    int          w;
    dir_tbl = '{
      '{ROW_REQ, CMD_DEQ, 8'h00, 8'h00, 16'h0000, 5'd0, 1'b1,
        '{1'b0, 8'h00, 8'h00, 16'h0000, STAT_EMPTY, 5'd0}},
      '{ROW_REQ, CMD_ENQ, 8'h00, 8'h00, 16'h0000, 5'd0, 1'b1,
        '{1'b0, 8'h00, 8'h00, 16'h0000, STAT_OK, 5'd1}},
      '{ROW_REQ, CMD_ENQ, 8'hff, 8'hff, 16'hffff, 5'd0, 1'b1,
        '{1'b0, 8'h00, 8'h00, 16'h0000, STAT_OK, 5'd2}},
      '{ROW_REQ, CMD_ENQ, 8'h12, 8'h34, 16'h8000, 5'd0, 1'b1,
        '{1'b0, 8'h00, 8'h00, 16'h0000, STAT_OK, 5'd3}},
      '{ROW_REQ, CMD_ENQ, 8'h56, 8'h78, 16'h8000, 5'd0, 1'b1,
        '{1'b0, 8'h00, 8'h00, 16'h0000, STAT_OK, 5'd4}},
      '{ROW_REQ, CMD_ENQ, 8'ha5, 8'h5a, 16'h8001, 5'd0, 1'b0, '0},
      '{ROW_REQ, CMD_DEQ, 8'hff, 8'hff, 16'hffff, 5'd0, 1'b1,
        '{1'b1, 8'hff, 8'hff, 16'hffff, STAT_OK, 5'd4}},
      '{ROW_REQ, CMD_DEQ, 8'h00, 8'h00, 16'h0000, 5'd0, 1'b0, '0},
      '{ROW_REQ, CMD_DEQ, 8'h00, 8'h00, 16'h0000, 5'd0, 1'b1,
        '{1'b1, 8'h12, 8'h34, 16'h8000, STAT_OK, 5'd2}},
      '{ROW_REQ, CMD_DEQ, 8'h00, 8'h00, 16'h0000, 5'd0, 1'b1,
        '{1'b1, 8'h56, 8'h78, 16'h8000, STAT_OK, 5'd1}},
      '{ROW_REQ, CMD_DEQ, 8'h00, 8'h00, 16'h0000, 5'd0, 1'b1,
        '{1'b1, 8'h00, 8'h00, 16'h0000, STAT_OK, 5'd0}},
      '{ROW_CAP, CMD_ENQ, 8'h00, 8'h00, 16'h0000, 5'd0, 1'b0, '0},
      '{ROW_REQ, CMD_ENQ, 8'haa, 8'h55, 16'h5555, 5'd0, 1'b1,
        '{1'b0, 8'h00, 8'h00, 16'h0000, STAT_OK, 5'd1}},
      '{ROW_REQ, CMD_ENQ, 8'h55, 8'haa, 16'haaaa, 5'd0, 1'b1,
        '{1'b0, 8'h00, 8'h00, 16'h0000, STAT_FULL, 5'd1}},
      '{ROW_REQ, CMD_DEQ, 8'hff, 8'hff, 16'hffff, 5'd0, 1'b1,
        '{1'b1, 8'haa, 8'h55, 16'h5555, STAT_OK, 5'd0}},
      '{ROW_REQ, CMD_DEQ, 8'hff, 8'hff, 16'hffff, 5'd0, 1'b1,
        '{1'b0, 8'h00, 8'h00, 16'h0000, STAT_EMPTY, 5'd0}},
      '{ROW_CAP, CMD_ENQ, 8'h00, 8'h00, 16'h0000, 5'd31, 1'b0, '0}
    };
    caps = '{5'd16, 5'd17, 5'd2, 5'd1, 5'd3, 5'($urandom_range(1, 16)),
             5'($urandom_range(1, 16)), 5'd31, 5'd8, 5'd16};

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_tbl[i]) begin
      if (dir_tbl[i].kind == ROW_CAP)
        set_capacity(dir_tbl[i].cap);
      else
        send_request(dir_tbl[i].cmd, dir_tbl[i].u, dir_tbl[i].t, dir_tbl[i].p,
                     dir_tbl[i].typed, dir_tbl[i].want);
    end

    foreach (caps[i]) begin
      set_capacity(caps[i]);
      if (i == 9) quiet = 1'b1;
      run_mix(PHASE_LEN);
    end
    s_tvalid <= 1'b0;

    w = 0;
    while (pending_results.size() != 0 && w < 20000) begin
      @(posedge clk);
      w++;
    end
    repeat (50) @(posedge clk);

    $display("ran %0d requests under %0d capacity writes (clamped 0 and 17/31 included)",
             n_requests, n_caps);
    $display("dequeued %0d entries, %0d full rejects, %0d empty rejects",
             n_served, n_full_rej, n_empty_rej);
    if (bad_cnt == 0 && pending_results.size() == 0) begin
      $display("[sorted_insert_priority_queue_top] OK");
    end else begin
      $display("%0d mismatches, %0d results missing", bad_cnt, pending_results.size());
      $display("[sorted_insert_priority_queue_top] ERROR");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout");
    $display("[sorted_insert_priority_queue_top] ERROR");
    $finish;
  end

endmodule
